@@ design/vcfc_pkg.sv @@
// Package for the voxel corner FIFO cache: shared constants, FSM state type
// and the probe record that walks the chain of tag cells.
// No dependencies.
package vcfc_pkg;

  // Fixed field widths.
  localparam int KEY_W     = 30;
  localparam int SIZE_W    = 11;
  localparam int CONT_W    = 3;
  localparam int SIDE_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int SLOT_OUT_W = 6;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CONTINUITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DIRECT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_HIT     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_KEY,
    ST_LAUNCH,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  // Lookup probe handed from cell to cell.
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] victim_tag;
  } probe_t;

endpackage

@@ design/vcfc_cell.sv @@
// One tag cell of the voxel corner FIFO cache chain: holds one slot's key,
// compares a passing probe against it and forwards the probe one cell on.
// Depends on vcfc_pkg.
module vcfc_cell #(
  parameter int SLOT_W   = 6,
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [CNT_W-1:0]             fill_i,
  input  logic [SLOT_W-1:0]            victim_i,
  input  logic                         wr_en_i,
  input  logic [SLOT_W-1:0]            wr_slot_i,
  input  logic [vcfc_pkg::KEY_W-1:0]   wr_key_i,
  input  vcfc_pkg::probe_t             probe_i,
  input  logic [SLOT_W-1:0]            slot_i,
  output vcfc_pkg::probe_t             probe_o,
  output logic [SLOT_W-1:0]            slot_o
);
  import vcfc_pkg::*;

  logic [KEY_W-1:0]  tag_q;
  logic              match;
  logic              active_q;
  logic              hit_q, hit_d;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  vtag_q, vtag_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  // The slot takes part only once it has been filled.
  assign match = probe_i.active && !probe_i.hit &&
                 (fill_i > CNT_W'(CELL_IDX)) && (tag_q == probe_i.key);

  // Record a hit here, and pick up the tag if this is the replacement slot.
  always_comb begin
    hit_d  = probe_i.hit;
    slot_d = slot_i;
    vtag_d = probe_i.victim_tag;
    if (match) begin
      hit_d  = 1'b1;
      slot_d = SLOT_W'(CELL_IDX);
    end
    if (victim_i == SLOT_W'(CELL_IDX)) begin
      vtag_d = tag_q;
    end
  end

  // Probe valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= probe_i.active;
    end
  end

  // Probe payload.
  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    key_q  <= probe_i.key;
    vtag_q <= vtag_d;
    slot_q <= slot_d;
  end

  // Tag storage for this slot.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_slot_i == SLOT_W'(CELL_IDX))) begin
      tag_q <= wr_key_i;
    end
  end

  assign probe_o = '{active: active_q, hit: hit_q, key: key_q, victim_tag: vtag_q};
  assign slot_o  = slot_q;

endmodule

@@ design/voxel_corner_fifo_cache.sv @@
// Voxel corner FIFO cache: neighborhood bounds test, linear key and a FIFO
// replacement tag lookup over a chain of CACHE_ENTRIES tag cells.
// Depends on vcfc_pkg and vcfc_cell.
// Sequence: a request is accepted in idle, then the product and key states run;
// outside or direct requests go straight to the finish state, cached requests
// launch a probe that walks one tag cell per cycle down the chain. One request is in
// work at a time; the next is taken in the cycle after the result is loaded.
// Reset: configuration returns to continuity 0 and extents 256, the cache is
// empty at once (fill count zero); there is no clearing pass.
module voxel_corner_fifo_cache #(
  parameter int CACHE_ENTRIES = 64,
  parameter int COORD_BITS    = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vcfc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vcfc_pkg::SIZE_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [COORD_BITS-1:0]             vx_i,
  input  logic [COORD_BITS-1:0]             vy_i,
  input  logic [COORD_BITS-1:0]             vz_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [vcfc_pkg::STATUS_W-1:0]     status_o,
  output logic [vcfc_pkg::SLOT_OUT_W-1:0]   slot_o,
  output logic [COORD_BITS-1:0]             fetch_x_o,
  output logic [COORD_BITS-1:0]             fetch_y_o,
  output logic [COORD_BITS-1:0]             fetch_z_o,
  output logic [vcfc_pkg::SIDE_W-1:0]       side_o,
  output logic [vcfc_pkg::KEY_W-1:0]        voxel_key_o,
  output logic                              evicted_o,
  output logic [vcfc_pkg::KEY_W-1:0]        evicted_key_o
);
  import vcfc_pkg::*;

  localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
  localparam int EW     = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;
  localparam int XP_W   = COORD_BITS + 2 * SIZE_W;
  localparam int PW     = (XP_W + 1 > KEY_W) ? XP_W + 1 : KEY_W;

  // Configuration registers.
  logic [CONT_W-1:0] cont_q;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q   <= '0;
      size_x_q <= SIZE_W'(256);
      size_y_q <= SIZE_W'(256);
      size_z_q <= SIZE_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CONTINUITY: cont_q   <= cfg_data_i[CONT_W-1:0];
        CFG_SIZE_X:     size_x_q <= cfg_data_i;
        CFG_SIZE_Y:     size_y_q <= cfg_data_i;
        CFG_SIZE_Z:     size_z_q <= cfg_data_i;
      endcase
    end
  end

  // Continuity decode, with out-of-range degrees clamped to -1 or 2.
  logic [SIDE_W-1:0] side;
  logic              off_neg;
  logic              cached;
  logic [2:0]        span;

  always_comb begin
    unique case (cont_q)
      3'b000:  begin side = 3'd2; off_neg = 1'b0; cached = 1'b1; end
      3'b001:  begin side = 3'd3; off_neg = 1'b1; cached = 1'b0; end
      3'b010:  begin side = 3'd4; off_neg = 1'b1; cached = 1'b0; end
      3'b011:  begin side = 3'd4; off_neg = 1'b1; cached = 1'b0; end
      default: begin side = 3'd1; off_neg = 1'b0; cached = 1'b0; end
    endcase
  end

  // Corner plus side, compared against the extent.
  assign span = side - {2'b00, off_neg};

  function automatic logic axis_out(input logic [COORD_BITS-1:0] c,
                                    input logic [2:0] sp,
                                    input logic [SIZE_W-1:0] size,
                                    input logic neg);
    logic [EW-1:0] hi;
    hi = EW'(c) + EW'(sp);
    return (neg && (c == '0)) || (hi >= EW'(size));
  endfunction

  // Controller state and handshake strobes.
  state_e state_q, state_d;
  logic   accept, launch, capture, load, out_free;
  logic   out_valid_q;
  probe_t probe [CACHE_ENTRIES+1];
  logic [SLOT_W-1:0] pslot [CACHE_ENTRIES+1];

  assign out_free = !out_valid_q || !out_stall_i;

  // Request registers and key arithmetic.
  logic [COORD_BITS-1:0]        x_q, y_q, z_q;
  logic [2*SIZE_W-1:0]          m1_q;
  logic [COORD_BITS+SIZE_W-1:0] m2_q;
  logic                         outside_q;
  logic [XP_W-1:0]              xp;
  logic [PW-1:0]                key_sum;
  logic [KEY_W-1:0]             key_q;

  assign xp      = x_q * m1_q;
  assign key_sum = PW'(xp) + PW'(m2_q) + PW'(z_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= vx_i;
      y_q <= vy_i;
      z_q <= vz_i;
    end
    if (state_q == ST_PROD) begin
      m1_q      <= size_y_q * size_z_q;
      m2_q      <= y_q * size_z_q;
      outside_q <= axis_out(x_q, span, size_x_q, off_neg) ||
                   axis_out(y_q, span, size_y_q, off_neg) ||
                   axis_out(z_q, span, size_z_q, off_neg);
    end
    if (state_q == ST_KEY) begin
      key_q <= key_sum[KEY_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PROD;
      ST_PROD:   state_d = ST_KEY;
      ST_KEY:    state_d = (!outside_q && cached) ? ST_LAUNCH : ST_FINISH;
      ST_LAUNCH: state_d = ST_SEARCH;
      ST_SEARCH: if (probe[CACHE_ENTRIES].active) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    launch     = 1'b0;
    capture    = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ST_LAUNCH: launch  = 1'b1;
      ST_SEARCH: capture = probe[CACHE_ENTRIES].active;
      ST_FINISH: load    = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Fill count and FIFO pointer.
  logic [CNT_W-1:0]  fill_q;
  logic [SLOT_W-1:0] oldest_q;
  logic              full;
  logic              wr_en;
  logic [SLOT_W-1:0] slot_sel;

  assign full = (fill_q == CNT_W'(CACHE_ENTRIES));

  // Chain of tag cells; the probe enters at cell zero.
  assign probe[0] = '{active: launch, hit: 1'b0, key: key_q, victim_tag: '0};
  assign pslot[0] = '0;

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    vcfc_cell #(
      .SLOT_W   (SLOT_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .fill_i    (fill_q),
      .victim_i  (oldest_q),
      .wr_en_i   (wr_en),
      .wr_slot_i (slot_sel),
      .wr_key_i  (key_q),
      .probe_i   (probe[g]),
      .slot_i    (pslot[g]),
      .probe_o   (probe[g+1]),
      .slot_o    (pslot[g+1])
    );
  end

  // Lookup result from the end of the chain.
  logic              hit_q;
  logic [SLOT_W-1:0] hslot_q;
  logic [KEY_W-1:0]  vtag_q;

  always_ff @(posedge clk_i) begin
    if (capture) begin
      hit_q   <= probe[CACHE_ENTRIES].hit;
      hslot_q <= pslot[CACHE_ENTRIES];
      vtag_q  <= probe[CACHE_ENTRIES].victim_tag;
    end
  end

  // Result selection.
  logic [STATUS_W-1:0]   status_d;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [COORD_BITS-1:0] fx_d, fy_d, fz_d;
  logic                  ev_d;
  logic [KEY_W-1:0]      evk_d;
  logic                  miss_wr;

  always_comb begin
    status_d = STATUS_OUTSIDE;
    slot_sel = '0;
    fx_d     = '0;
    fy_d     = '0;
    fz_d     = '0;
    ev_d     = 1'b0;
    evk_d    = '0;
    miss_wr  = 1'b0;
    if (!outside_q) begin
      fx_d = x_q - COORD_BITS'(off_neg);
      fy_d = y_q - COORD_BITS'(off_neg);
      fz_d = z_q - COORD_BITS'(off_neg);
    end
    priority if (outside_q) begin
      status_d = STATUS_OUTSIDE;
    end else if (!cached) begin
      status_d = STATUS_DIRECT;
    end else if (hit_q) begin
      status_d = STATUS_HIT;
      slot_sel = hslot_q;
    end else begin
      status_d = STATUS_MISS;
      miss_wr  = 1'b1;
      if (full) begin
        slot_sel = oldest_q;
        ev_d     = 1'b1;
        evk_d    = vtag_q;
      end else begin
        slot_sel = fill_q[SLOT_W-1:0];
      end
    end
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_sel};
  assign wr_en    = load && miss_wr;

  // Replacement bookkeeping: fill first, then rotate over all slots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      oldest_q <= '0;
    end else if (wr_en) begin
      if (full) begin
        oldest_q <= (oldest_q == SLOT_W'(CACHE_ENTRIES - 1)) ? '0 : oldest_q + SLOT_W'(1);
      end else begin
        fill_q <= fill_q + CNT_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_o      <= status_d;
      slot_o        <= slot_ext[SLOT_OUT_W-1:0];
      fetch_x_o     <= fx_d;
      fetch_y_o     <= fy_d;
      fetch_z_o     <= fz_d;
      side_o        <= side;
      voxel_key_o   <= key_q;
      evicted_o     <= ev_d;
      evicted_key_o <= evk_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
